// File: rtl/jdz_pkg.sv
// Shared types and constants for the joystick dead-zone unit.
// Used by the channel interfaces and by joystick_dead_zone_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jdz_pkg;

  // Component format: signed Q2.14.
  localparam int CompWidth  = 16;
  localparam int FracBits   = 14;
  localparam int ThrWidth   = 15;
  localparam int KindWidth  = 2;
  localparam int NumAxes    = 3;
  localparam logic [CompWidth-1:0] QOne = 16'd16384;

  // Derived widths of the datapath.
  localparam int MagWidth   = CompWidth;
  localparam int SqWidth    = 2 * CompWidth - 1;
  localparam int SumWidth   = 2 * CompWidth;
  localparam int RootWidth  = CompWidth;
  localparam int RemWidth   = RootWidth + 2;
  localparam int QuoWidth   = FracBits + 1;
  localparam int DenWidth   = 2 * CompWidth;
  localparam int NumWidth   = 2 * CompWidth + FracBits + 1;

  // Pipeline layout.
  localparam int StSquare   = 1;
  localparam int StSum      = 2;
  localparam int StSqrt0    = 3;
  localparam int SqrtSteps  = SumWidth / 2;
  localparam int StSetup    = StSqrt0 + SqrtSteps;
  localparam int StDiv0     = StSetup + 1;
  localparam int DivSteps   = QuoWidth;
  localparam int StOut      = StDiv0 + DivSteps;
  localparam int NumStages  = StOut + 1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RADIAL_MODE = 2'd0,
    CFG_LOWER       = 2'd1,
    CFG_UPPER       = 2'd2
  } cfg_reg_t;

  // What a component resolves to.
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ONE  = 2'd1,
    RES_DIV  = 2'd2
  } res_code_t;

  // One word as it travels down the pipeline.
  typedef struct packed {
    logic [KindWidth-1:0]                 kind;
    logic [NumAxes-1:0]                   neg;
    logic [NumAxes-1:0][MagWidth-1:0]     mag;
    logic [NumAxes-1:0][SqWidth-1:0]      sq;
    logic [SumWidth-1:0]                  s;
    logic [RemWidth-1:0]                  rem;
    logic [RootWidth-1:0]                 root;
    res_code_t [NumAxes-1:0]              code;
    logic [NumAxes-1:0][NumWidth-1:0]     num;
    logic [NumAxes-1:0][DenWidth-1:0]     den;
    logic [NumAxes-1:0][QuoWidth-1:0]     q;
    logic [NumAxes-1:0][CompWidth-1:0]    res;
  } jdz_word_t;

endpackage

`default_nettype wire

// File: rtl/jdz_in_if.sv
// Sample channel: valid/ready handshake with three components and a kind tag.
// Depends on jdz_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jdz_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [jdz_pkg::CompWidth-1:0]  x_in;
  logic signed [jdz_pkg::CompWidth-1:0]  y_in;
  logic signed [jdz_pkg::CompWidth-1:0]  z_in;
  logic [jdz_pkg::KindWidth-1:0]         value_kind;

  modport source (output valid, x_in, y_in, z_in, value_kind, input ready);
  modport sink   (input valid, x_in, y_in, z_in, value_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/jdz_out_if.sv
// Result channel: valid/ready handshake with conditioned components and kind tag.
// Depends on jdz_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jdz_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [jdz_pkg::CompWidth-1:0]  x_out;
  logic signed [jdz_pkg::CompWidth-1:0]  y_out;
  logic signed [jdz_pkg::CompWidth-1:0]  z_out;
  logic [jdz_pkg::KindWidth-1:0]         value_kind_out;

  modport source (output valid, x_out, y_out, z_out, value_kind_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, value_kind_out, output ready);
endinterface

`default_nettype wire

// File: rtl/jdz_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on jdz_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jdz_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        index;
  logic [jdz_pkg::ThrWidth-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/joystick_dead_zone_unit.sv
// Joystick dead-zone unit: axial or radial dead zone on a three-axis Q2.14 sample.
// One word per cycle sustained while the result channel keeps ready high.
// The depth is set by the 16-step square-root pipeline and the 15-step divider.
// Each stage holds its word under back-pressure, so empty stages still fill up.
// Synchronous reset clears all valid bits and restores the register defaults.
// Depends on jdz_pkg, jdz_in_if, jdz_out_if and jdz_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module joystick_dead_zone_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  jdz_in_if.sink      sample,
  jdz_out_if.source   result,
  jdz_cfg_if.sink     cfg
);
  import jdz_pkg::*;

  logic                          radial_mode;
  logic [ThrWidth-1:0]           lower_threshold;
  logic [ThrWidth-1:0]           upper_threshold;
  logic [2*ThrWidth-1:0]         lower_sq;
  logic [2*ThrWidth-1:0]         upper_sq;

  jdz_word_t                     pipe [NumStages];
  jdz_word_t                     nxt  [NumStages];
  logic [NumStages-1:0]          vld;
  logic [NumStages-1:0]          en;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radial_mode     <= 1'b0;
      lower_threshold <= 15'd3277;
      upper_threshold <= 15'd16384;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_RADIAL_MODE: radial_mode     <= cfg.data[0];
        CFG_LOWER:       lower_threshold <= cfg.data;
        CFG_UPPER:       upper_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  // Squared thresholds for the radial compare, refreshed every cycle.
  always_ff @(posedge clk) begin
    lower_sq <= lower_threshold * lower_threshold;
    upper_sq <= upper_threshold * upper_threshold;
  end

  // A stage may load when it is empty or its word moves on.
  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || result.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign sample.ready = en[0];

  // Stage logic: each stage computes its word from the one before.
  always_comb begin
    logic signed [CompWidth-1:0] vin [NumAxes];
    logic [SumWidth-1:0]         sum;
    logic [RemWidth+1:0]         cur;
    logic [RemWidth-1:0]         trial;
    logic [RootWidth-1:0]        m;
    logic [ThrWidth-1:0]         span;
    logic [RootWidth-1:0]        m_less;
    logic [NumWidth-1:0]         shifted;
    logic [CompWidth-1:0]        qmag;
    int                          j;
    int                          b;

    vin[0] = sample.x_in;
    vin[1] = sample.y_in;
    vin[2] = sample.z_in;
    sum    = '0;
    cur    = '0;
    trial  = '0;
    m      = '0;
    span   = '0;
    m_less = '0;
    shifted = '0;
    qmag   = '0;
    j      = 0;
    b      = 0;

    // Input stage: sign and magnitude of each component.
    nxt[0] = '0;
    nxt[0].kind = sample.value_kind;
    for (int i = 0; i < NumAxes; i++) begin
      nxt[0].neg[i] = vin[i][CompWidth-1];
      nxt[0].mag[i] = vin[i][CompWidth-1] ? MagWidth'(-vin[i]) : MagWidth'(vin[i]);
    end

    for (int k = 1; k < NumStages; k++) begin
      nxt[k] = pipe[k-1];

      if (k == StSquare) begin
        // Squares of the magnitudes.
        for (int i = 0; i < NumAxes; i++) begin
          nxt[k].sq[i] = SqWidth'(pipe[k-1].mag[i]) * SqWidth'(pipe[k-1].mag[i]);
        end
      end else if (k == StSum) begin
        // Squared length, and the root iteration is primed.
        sum = SumWidth'(pipe[k-1].sq[0]) + SumWidth'(pipe[k-1].sq[1])
            + SumWidth'(pipe[k-1].sq[2]);
        nxt[k].s    = sum;
        nxt[k].rem  = '0;
        nxt[k].root = '0;
      end else if (k >= StSqrt0 && k < StSetup) begin
        // One digit of the integer square root, two bits of s per step.
        j     = k - StSqrt0;
        cur   = {pipe[k-1].rem, pipe[k-1].s[SumWidth-1-2*j -: 2]};
        trial = {pipe[k-1].root, 2'b01};
        if (cur >= (RemWidth+2)'(trial)) begin
          nxt[k].rem  = RemWidth'(cur - (RemWidth+2)'(trial));
          nxt[k].root = {pipe[k-1].root[RootWidth-2:0], 1'b1};
        end else begin
          nxt[k].rem  = RemWidth'(cur);
          nxt[k].root = {pipe[k-1].root[RootWidth-2:0], 1'b0};
        end
      end else if (k == StSetup) begin
        // Decide each component's outcome and set up dividend and divisor.
        m      = pipe[k-1].root;
        span   = upper_threshold - lower_threshold;
        m_less = m - RootWidth'(lower_threshold);
        for (int i = 0; i < NumAxes; i++) begin
          nxt[k].q[i]    = '0;
          nxt[k].num[i]  = '0;
          nxt[k].den[i]  = DenWidth'(1);
          nxt[k].code[i] = RES_ZERO;
          if (radial_mode) begin
            if (pipe[k-1].s < SumWidth'(lower_sq)) begin
              nxt[k].code[i] = RES_ZERO;
            end else if (pipe[k-1].s > SumWidth'(upper_sq)) begin
              nxt[k].code[i] = RES_DIV;
              nxt[k].num[i]  = NumWidth'(pipe[k-1].mag[i]) << FracBits;
              nxt[k].den[i]  = DenWidth'(m);
            end else if (span != '0 && m != '0) begin
              nxt[k].code[i] = RES_DIV;
              nxt[k].num[i]  = (NumWidth'(pipe[k-1].mag[i]) * NumWidth'(m_less))
                             << FracBits;
              nxt[k].den[i]  = DenWidth'(span) * DenWidth'(m);
            end
          end else begin
            if (pipe[k-1].mag[i] < MagWidth'(lower_threshold)) begin
              nxt[k].code[i] = RES_ZERO;
            end else if (pipe[k-1].mag[i] > MagWidth'(upper_threshold)) begin
              nxt[k].code[i] = RES_ONE;
            end else if (span != '0) begin
              nxt[k].code[i] = RES_DIV;
              nxt[k].num[i]  = NumWidth'(pipe[k-1].mag[i]
                             - MagWidth'(lower_threshold)) << FracBits;
              nxt[k].den[i]  = DenWidth'(span);
            end
          end
        end
      end else if (k >= StDiv0 && k < StOut) begin
        // One quotient bit per stage, most significant first.
        b = QuoWidth - 1 - (k - StDiv0);
        for (int i = 0; i < NumAxes; i++) begin
          shifted = NumWidth'(pipe[k-1].den[i]) << b;
          if (pipe[k-1].num[i] >= shifted) begin
            nxt[k].num[i]    = pipe[k-1].num[i] - shifted;
            nxt[k].q[i][b]   = 1'b1;
          end
        end
      end else if (k == StOut) begin
        // Pick the magnitude and restore the sign.
        for (int i = 0; i < NumAxes; i++) begin
          case (pipe[k-1].code[i])
            RES_ONE: qmag = QOne;
            RES_DIV: qmag = CompWidth'(pipe[k-1].q[i]);
            default: qmag = '0;
          endcase
          nxt[k].res[i] = pipe[k-1].neg[i] ? CompWidth'(-qmag) : qmag;
        end
      end
    end
  end

  // Pipeline registers; payload carries no reset.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Output register drives the result channel.
  assign result.valid          = vld[NumStages-1];
  assign result.x_out          = pipe[NumStages-1].res[0];
  assign result.y_out          = pipe[NumStages-1].res[1];
  assign result.z_out          = pipe[NumStages-1].res[2];
  assign result.value_kind_out = pipe[NumStages-1].kind;

endmodule

`default_nettype wire

// File: bench/tb_joystick_dead_zone_unit.sv
// Self-checking bench for joystick_dead_zone_unit: directed table, random samples, then setting phases.
// Depends on jdz_pkg, jdz_in_if, jdz_out_if, jdz_cfg_if and the unit itself.
`timescale 1ns / 1ps

module tb_joystick_dead_zone_unit;
  import jdz_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         kind;
  } stick_word_t;

  typedef struct {
    stick_word_t smp;
    bit          known;
    stick_word_t res;
  } dz_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jdz_in_if  sample ();
  jdz_out_if result ();
  jdz_cfg_if cfg ();

  joystick_dead_zone_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  always #1 clk = ~clk;

  // Local copy of the register settings.
  bit         radial_q;
  logic [14:0] lower_q;
  logic [14:0] upper_q;

  stick_word_t pending_words[$];
  int          errors;
  int          idle_cycles;
  bit          long_hold;

  // Integer square root, floor.
  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Per-axis dead zone with linear rescale between the edges.
  function automatic logic signed [15:0] axial_zone(logic signed [15:0] v);
    longint a;
    longint span;
    longint m;
    a = (v < 0) ? -longint'(v) : longint'(v);
    if (a < lower_q) return 16'sd0;
    if (a > upper_q) return (v > 0) ? 16'sd16384 : -16'sd16384;
    span = longint'(upper_q) - longint'(lower_q);
    if (span == 0) return 16'sd0;
    m = (a - lower_q) * 16384 / span;
    return 16'((v < 0) ? -m : m);
  endfunction

  // Expected conditioned sample for the current settings.
  function automatic stick_word_t dead_zone(stick_word_t w);
    stick_word_t r;
    longint v[3];
    longint a[3];
    longint unsigned s;
    longint unsigned m;
    longint unsigned q;
    longint unsigned num;
    longint unsigned den;
    longint o[3];
    r.kind = w.kind;
    v[0] = w.x; v[1] = w.y; v[2] = w.z;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (v[i] < 0) ? -v[i] : v[i];
      s += a[i] * a[i];
      o[i] = 0;
    end
    if (!radial_q) begin
      r.x = axial_zone(w.x); r.y = axial_zone(w.y); r.z = axial_zone(w.z);
      return r;
    end
    m = floor_root(s);
    if (s < longint'(lower_q) * lower_q) begin
    end else if (s > longint'(upper_q) * upper_q) begin
      for (int i = 0; i < 3; i++) begin
        q = a[i] * 16384 / m;
        o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end else if (upper_q != lower_q && m != 0) begin
      den = (longint'(upper_q) - lower_q) * m;
      num = (m - lower_q) * 16384;
      for (int i = 0; i < 3; i++) begin
        q = a[i] * num / den;
        o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    r.x = 16'(o[0]); r.y = 16'(o[1]); r.z = 16'(o[2]);
    return r;
  endfunction

  // Write one register; block must be idle. The channel is left quiet after each write before the task returns.
  task automatic write_reg(cfg_reg_t idx, logic [14:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_RADIAL_MODE: radial_q = val[0];
      CFG_LOWER:       lower_q = val;
      CFG_UPPER:       upper_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one sample word after a random gap; record its expectation on acceptance.
  // Valid stays high after acceptance so that the next word can follow at once.
  task automatic send_word(stick_word_t w, bit known, stick_word_t res);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid      <= 1'b1;
    sample.x_in       <= w.x;
    sample.y_in       <= w.y;
    sample.z_in       <= w.z;
    sample.value_kind <= w.kind;
    do @(posedge clk); while (!sample.ready);
    pending_words.push_back(known ? res : dead_zone(w));
  endtask

  // Stop offering words and wait for every expected word to come back.
  task automatic drain;
    sample.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'sd16384 - 16'($urandom_range(0, 200));
      2: return -16'sd16384 + 16'($urandom_range(0, 200));
      3: return 16'($urandom_range(0, 6000)) - 16'sd3000;
      default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  task automatic random_words(int n);
    stick_word_t w;
    for (int k = 0; k < n; k++) begin
      w.x = rand_comp(); w.y = rand_comp(); w.z = rand_comp();
      w.kind = 2'($urandom_range(0, 3));
      send_word(w, 1'b0, w);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off.
  always @(posedge clk) begin
    int wait_left;
    if (rst) begin
      result.ready <= 1'b0;
      wait_left = 0;
    end else if (long_hold) begin
      result.ready <= 1'b0;
    end else if (result.valid && result.ready) begin
      wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      result.ready <= (wait_left == 0);
    end else if (wait_left > 0) begin
      wait_left--;
      result.ready <= (wait_left == 0);
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    stick_word_t e;
    if (!rst && result.valid && result.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d kind=%0d", $time,
                 result.x_out, result.y_out, result.z_out, result.value_kind_out);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (result.x_out !== e.x || result.y_out !== e.y || result.z_out !== e.z ||
            result.value_kind_out !== e.kind) begin
          $display("%0t: expected x=%0d y=%0d z=%0d kind=%0d, got x=%0d y=%0d z=%0d kind=%0d",
                   $time, e.x, e.y, e.z, e.kind, result.x_out, result.y_out,
                   result.z_out, result.value_kind_out);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all, outside the long hold-off.
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready) || long_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Directed table: zeros, extremes, edges and kinds under the reset settings.
  dz_row_t directed[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 2'd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 2'd0}},
    '{'{16'sd32767, -16'sd32768, 16'sd0, 2'd3}, 1'b1,
      '{16'sd16384, -16'sd16384, 16'sd0, 2'd3}},
    '{'{16'sd16384, -16'sd16384, 16'sd3276, 2'd1}, 1'b1,
      '{16'sd16384, -16'sd16384, 16'sd0, 2'd1}},
    '{'{16'sd3277, -16'sd3277, 16'sd16385, 2'd2}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd16384, 2'd2}},
    '{'{16'sd8000, -16'sd9000, 16'sd12000, 2'd3}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 2'd0}},
    '{'{-16'sd1, 16'sd1, -16'sd5000, 2'd0}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 2'd0}}
  };

  stick_word_t edge_words[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 2'd0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 2'd3},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 2'd2},
    '{16'sd3000, 16'sd0, 16'sd0, 2'd1},
    '{16'sd0, -16'sd9000, 16'sd4000, 2'd1},
    '{16'sd16384, 16'sd0, 16'sd0, 2'd3}
  };

  // Settings walked in turn: mode, lower, upper.
  logic [14:0] phases[][3] = '{
    '{15'd1, 15'd3277, 15'd16384},
    '{15'd1, 15'd0, 15'd0},
    '{15'd0, 15'd0, 15'd0},
    '{15'd0, 15'd8000, 15'd8000},
    '{15'd1, 15'd8000, 15'd8000},
    '{15'd0, 15'd12000, 15'd4000},
    '{15'd1, 15'd12000, 15'd4000},
    '{15'd0, 15'd32767, 15'd32767},
    '{15'd1, 15'd16384, 15'd32767},
    '{15'd0, 15'd1000, 15'd20000},
    '{15'd1, 15'd0, 15'd16384},
    '{15'd0, 15'd3277, 15'd16384}
  };

  initial begin
    errors = 0;
    long_hold = 1'b0;
    radial_q = 1'b0;
    lower_q = 15'd3277;
    upper_q = 15'd16384;
    sample.valid <= 1'b0;
    sample.x_in <= '0;
    sample.y_in <= '0;
    sample.z_in <= '0;
    sample.value_kind <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_RADIAL_MODE;
    cfg.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i].smp, directed[i].known, directed[i].res);
    random_words(230);

    // Long receiver hold-off while samples keep coming.
    fork
      begin
        long_hold = 1'b1;
        repeat (120) @(posedge clk);
        long_hold = 1'b0;
      end
      random_words(100);
    join
    drain();

    foreach (phases[p]) begin
      write_reg(CFG_RADIAL_MODE, phases[p][0]);
      write_reg(CFG_LOWER, phases[p][1]);
      write_reg(CFG_UPPER, phases[p][2]);
      foreach (edge_words[i]) send_word(edge_words[i], 1'b0, edge_words[i]);
      random_words(120);
      drain();
    end

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
